>>> sv/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// shared types, function codes and status codes of the sorted table
// ----------------------------------------------------------------------------
package sti_pkg;

    localparam int VAL_W        = 32;
    localparam int CAPACITY_DEF = 16;

    // function codes
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;
    localparam logic [1:0] FN_READ   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_DONE
    } t_state;

    // result of the shared comparator
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

>>> sv/sti_if.sv
// ----------------------------------------------------------------------------
// sti_if
// request and response channels of the sorted table
// ----------------------------------------------------------------------------
interface sti_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  func;
    logic signed [31:0] value;
    logic        [3:0]  position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface sti_rsp_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status;
    logic signed [31:0] read_value;
    logic        [4:0]  entry_count;

    modport source (output valid, output status, output read_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    output ready);
endinterface

>>> sv/sti_ram.sv
// ----------------------------------------------------------------------------
// sti_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sti_cmp.sv
// ----------------------------------------------------------------------------
// sti_cmp
// shared signed comparator used by the insert and remove scans
// ----------------------------------------------------------------------------
module sti_cmp (
    input  logic signed [sti_pkg::VAL_W-1:0] i_a,
    input  logic signed [sti_pkg::VAL_W-1:0] i_b,
    output sti_pkg::t_cmp                    o_cmp
);
    import sti_pkg::*;

    always_comb begin
        o_cmp.lt = (i_a < i_b);
        o_cmp.eq = (i_a == i_b);
    end

endmodule

>>> sv/sorted_table_insert_remove_top.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_top
// bounded ascending table of signed values with insert, remove, clear, read
// ----------------------------------------------------------------------------
// The table sits in one ram with a registered read port, and a small sequencer
// walks it entry by entry, reading each entry in S_RD, then comparing and
// writing back in S_EX, through a single shared comparator. One item is
// worked on at a time and the request channel is ready only when the sequencer
// is idle; a finished result waits in the output register while the next item
// is accepted.
module sorted_table_insert_remove_top #(
    parameter int CAPACITY = sti_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sti_req_if.sink   i_req,
    sti_rsp_if.source o_rsp
);
    import sti_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic [1:0]         r_func, n_func;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [VAL_W-1:0]   r_carry, n_carry;
    logic               r_flag, n_flag;
    logic [2:0]         r_status, n_status;
    logic [VAL_W-1:0]   r_rd, n_rd;

    logic               r_ovalid, n_ovalid;
    logic [2:0]         r_o_status, n_o_status;
    logic [VAL_W-1:0]   r_o_rd, n_o_rd;
    logic [4:0]         r_o_cnt, n_o_cnt;

    logic               w_accept;
    logic               w_load;
    logic               w_last;
    logic               w_re;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [VAL_W-1:0]   w_wdata;
    logic [VAL_W-1:0]   w_rdata;
    logic [CW-1:0]      w_idx_m1;
    t_cmp               w_cmp;

    sti_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    sti_cmp u_cmp (
        .i_a   ($signed(w_rdata)),
        .i_b   ($signed(r_val)),
        .o_cmp (w_cmp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_last      = (r_idx == r_cnt);
    assign w_idx_m1    = r_idx - CW'(1);

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.read_value  = $signed(r_o_rd);
    assign o_rsp.entry_count = r_o_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_func     <= n_func;
        r_val      <= n_val;
        r_carry    <= n_carry;
        r_flag     <= n_flag;
        r_status   <= n_status;
        r_rd       <= n_rd;
        r_o_status <= n_o_status;
        r_o_rd     <= n_o_rd;
        r_o_cnt    <= n_o_cnt;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_func     = r_func;
        n_val      = r_val;
        n_carry    = r_carry;
        n_flag     = r_flag;
        n_status   = r_status;
        n_rd       = r_rd;
        n_ovalid   = r_ovalid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_rd     = r_o_rd;
        n_o_cnt    = r_o_cnt;
        w_load     = 1'b0;
        w_re       = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_idx[AW-1:0];
        w_wdata    = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_func   = i_req.func;
                    n_val    = i_req.value;
                    n_idx    = '0;
                    n_flag   = 1'b0;
                    n_status = ST_OK;
                    n_rd     = '0;
                    unique case (i_req.func)
                        FN_INSERT: begin
                            if (r_cnt >= CAP) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        FN_REMOVE: begin
                            n_state = S_RD;
                        end
                        FN_CLEAR: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt = '0;
                            end
                            n_state = S_DONE;
                        end
                        default: begin
                            // read at position
                            if (int'(i_req.position) >= int'(r_cnt)) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_idx   = CW'(i_req.position);
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                w_re = !w_last;
                if (r_func == FN_REMOVE && w_last) begin
                    if (r_flag) begin
                        n_cnt = r_cnt - CW'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_EX;
                end
            end
            S_EX: begin
                unique case (r_func)
                    FN_INSERT: begin
                        // slide every value from the insertion point up by one
                        if (!r_flag && (w_last || !w_cmp.lt)) begin
                            w_we    = 1'b1;
                            w_wdata = r_val;
                            n_carry = w_rdata;
                            n_flag  = 1'b1;
                        end else if (r_flag) begin
                            w_we    = 1'b1;
                            w_wdata = r_carry;
                            n_carry = w_rdata;
                        end
                        if (w_last) begin
                            n_cnt   = r_cnt + CW'(1);
                            n_state = S_DONE;
                        end else begin
                            n_idx   = r_idx + CW'(1);
                            n_state = S_RD;
                        end
                    end
                    FN_REMOVE: begin
                        // after the first match, move each value down by one
                        if (r_flag) begin
                            w_we    = 1'b1;
                            w_waddr = w_idx_m1[AW-1:0];
                            w_wdata = w_rdata;
                        end else if (w_cmp.eq) begin
                            n_flag = 1'b1;
                        end
                        n_idx   = r_idx + CW'(1);
                        n_state = S_RD;
                    end
                    default: begin
                        n_rd    = w_rdata;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    w_load     = 1'b1;
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_rd     = r_rd;
                    n_o_cnt    = 5'(r_cnt);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP)
        else $error("entry count above capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_EX) |-> r_idx <= r_cnt)
        else $error("scan index beyond entry count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_status == ST_FULL) |-> r_cnt == CAP)
        else $error("full reported on a table that is not full");

    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_ovalid && r_o_cnt == 5'(r_cnt)))
        else $error("result count does not match table count");

endmodule
